// ===== rtl/qact_pkg.sv =====
// Package for the quote-aware command tokenizer.
// Holds the byte codes, the result kinds, the scan-mode encoding and the shared structs.
// Has no dependencies of its own.
package qact_pkg;

    // Bytes that steer the scanner.
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE = 8'h27;
    localparam logic [7:0] CHAR_PIPE   = 8'h7C;

    // Result kinds as they appear on the output port.
    localparam logic [2:0] KIND_CHAR = 3'd0;
    localparam logic [2:0] KIND_END  = 3'd1;
    localparam logic [2:0] KIND_PIPE = 3'd2;
    localparam logic [2:0] KIND_EOL  = 3'd3;
    localparam logic [2:0] KIND_ERR  = 3'd4;

    // Scan mode, one-hot.
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_TOKEN = 3'b010,
        MODE_QUOTE = 3'b100
    } mode_t;

    // One result word.
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] char_out;
        logic       last;
    } result_t;

    // What one input byte does: up to two results and the next scanner state.
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
        mode_t      next_mode;
        logic       next_dq;
    } decode_t;

endpackage

// ===== rtl/qact_decode.sv =====
// Byte classifier and next-state logic of the tokenizer.
// Purely combinational; depends on qact_pkg.
module qact_decode import qact_pkg::*; (
    input  logic [7:0] char_i,
    input  mode_t      mode_i,
    input  logic       dq_i,
    output decode_t    dec_o
);

    logic [7:0] closer;
    logic       is_sep;
    logic       is_quote;

    assign closer   = dq_i ? CHAR_DQUOTE : CHAR_SQUOTE;
    assign is_sep   = char_i inside {CHAR_SPACE, CHAR_NL};
    assign is_quote = char_i inside {CHAR_SQUOTE, CHAR_DQUOTE};

    always_comb begin
        dec_o           = '0;
        dec_o.next_mode = mode_i;
        dec_o.next_dq   = dq_i;
        case (mode_i)
            MODE_QUOTE: begin
                if (char_i == CHAR_NUL) begin
                    dec_o.count     = 2'd1;
                    dec_o.res0.kind = KIND_ERR;
                    dec_o.next_mode = MODE_IDLE;
                    dec_o.next_dq   = 1'b0;
                end else if (char_i == closer) begin
                    dec_o.next_mode = MODE_TOKEN;
                end else begin
                    dec_o.count         = 2'd1;
                    dec_o.res0.kind     = KIND_CHAR;
                    dec_o.res0.char_out = char_i;
                end
            end
            MODE_TOKEN: begin
                if (char_i == CHAR_NUL) begin
                    dec_o.count     = 2'd2;
                    dec_o.res0.kind = KIND_END;
                    dec_o.res1.kind = KIND_EOL;
                    dec_o.next_mode = MODE_IDLE;
                end else if (is_sep) begin
                    dec_o.count     = 2'd1;
                    dec_o.res0.kind = KIND_END;
                    dec_o.next_mode = MODE_IDLE;
                end else if (char_i == CHAR_PIPE) begin
                    dec_o.count     = 2'd2;
                    dec_o.res0.kind = KIND_END;
                    dec_o.res1.kind = KIND_PIPE;
                    dec_o.next_mode = MODE_IDLE;
                end else if (is_quote) begin
                    dec_o.next_dq   = (char_i == CHAR_DQUOTE);
                    dec_o.next_mode = MODE_QUOTE;
                end else begin
                    dec_o.count         = 2'd1;
                    dec_o.res0.kind     = KIND_CHAR;
                    dec_o.res0.char_out = char_i;
                end
            end
            default: begin
                // Idle between tokens.
                if (char_i == CHAR_NUL) begin
                    dec_o.count     = 2'd1;
                    dec_o.res0.kind = KIND_EOL;
                    dec_o.next_mode = MODE_IDLE;
                end else if (is_sep) begin
                    dec_o.next_mode = MODE_IDLE;
                end else if (char_i == CHAR_PIPE) begin
                    dec_o.count     = 2'd1;
                    dec_o.res0.kind = KIND_PIPE;
                    dec_o.next_mode = MODE_IDLE;
                end else if (is_quote) begin
                    dec_o.next_dq   = (char_i == CHAR_DQUOTE);
                    dec_o.next_mode = MODE_QUOTE;
                end else begin
                    dec_o.count         = 2'd1;
                    dec_o.res0.kind     = KIND_CHAR;
                    dec_o.res0.char_out = char_i;
                    dec_o.next_mode     = MODE_TOKEN;
                end
            end
        endcase
        dec_o.res0.last = (dec_o.count == 2'd1);
        dec_o.res1.last = 1'b1;
    end

endmodule

// ===== rtl/quote_aware_command_tokenizer.sv =====
// Top level of the quote-aware command tokenizer.
// Depends on qact_pkg and qact_decode.
//
// The tokenizer takes a command line one byte per word on the s_ channel and
// streams out results on the m_ channel: token characters, token-end marks,
// pipe tokens, an end-of-line mark for a zero byte, and an unclosed-quote error
// when the line ends inside a quoted span. Quote bytes are dropped, and
// everything inside a span is literal. Each input word gives zero, one or two
// result words, and m_last marks the final one for its input word. An input
// word is held in the input register and decoded from there, and its results
// enter a two-word output queue whose head drives the m_ ports. The block takes
// one input word per cycle as long as the results drain at one word per cycle;
// the output port moves one word per cycle while m_ready is high, so a byte
// that gives two results needs two words on the output side. A byte that
// gives no result still advances the scanner state.
module quote_aware_command_tokenizer import qact_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_char_out,
    output logic       m_last
);

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;

    // Scanner state.
    mode_t mode_reg, mode_next;
    logic  dq_reg, dq_next;

    // Output queue: entry 0 is the head shown on the m_ ports.
    result_t    q_reg [2];
    result_t    q_next [2];
    logic [1:0] count_reg, count_next;

    decode_t    dec;
    logic       pop;
    logic [1:0] cnt_ap;
    logic [1:0] push_n;
    logic [2:0] room_sum;
    logic [2:0] new_count;
    logic       fits;
    logic       adv;
    result_t    shifted0;

    qact_decode u_decode (
        .char_i (in_char_reg),
        .mode_i (mode_reg),
        .dq_i   (dq_reg),
        .dec_o  (dec)
    );

    assign m_valid    = (count_reg != 2'd0);
    assign m_kind     = q_reg[0].kind;
    assign m_char_out = q_reg[0].char_out;
    assign m_last     = q_reg[0].last;

    assign pop      = m_valid && m_ready;
    assign cnt_ap   = count_reg - {1'b0, pop};
    assign room_sum = {1'b0, cnt_ap} + {1'b0, dec.count};
    assign fits     = (room_sum <= 3'd2);

    // The registered byte retires when all of its results fit in the queue.
    assign adv     = in_valid_reg && fits;
    assign s_ready = !in_valid_reg || adv;
    assign push_n  = adv ? dec.count : 2'd0;

    assign in_valid_next = s_ready ? s_valid : in_valid_reg;
    assign mode_next     = adv ? dec.next_mode : mode_reg;
    assign dq_next       = adv ? dec.next_dq : dq_reg;

    assign shifted0  = pop ? q_reg[1] : q_reg[0];
    assign new_count = {1'b0, cnt_ap} + {1'b0, push_n};

    always_comb begin
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        // Head slot: keep what remains, else take the first new result.
        if (cnt_ap != 2'd0) begin
            q_next[0] = shifted0;
        end else if (push_n != 2'd0) begin
            q_next[0] = dec.res0;
        end
        // Second slot.
        if (cnt_ap == 2'd2) begin
            q_next[1] = q_reg[1];
        end else if (cnt_ap == 2'd1 && push_n != 2'd0) begin
            q_next[1] = dec.res0;
        end else if (cnt_ap == 2'd0 && push_n == 2'd2) begin
            q_next[1] = dec.res1;
        end
        count_next = new_count[1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_IDLE;
            dq_reg       <= 1'b0;
            count_reg    <= 2'd0;
        end else begin
            in_valid_reg <= in_valid_next;
            mode_reg     <= mode_next;
            dq_reg       <= dq_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_char_in;
        end
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

endmodule
